/* rtl/core/sssa_pkg.sv */
package sssa_pkg;

    // Field widths fixed by the event format.
    localparam int VALUE_W    = 16;
    localparam int TIME_W     = 32;
    localparam int SENS_W     = 8;
    localparam int OUT_W      = 24;
    localparam int DECAY_W    = 16;
    localparam int GAIN_CFG_W = 7;
    localparam int MINMOV_W   = 15;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOVEMENT = 2'd2;

    localparam logic [DECAY_W-1:0]    DECAY_RESET  = 16'd100;
    localparam logic [GAIN_CFG_W-1:0] GAIN_RESET   = 7'd10;
    localparam logic [MINMOV_W-1:0]   MINMOV_RESET = 15'd1;

    // Internal datapath widths.
    localparam int MOV_W       = 16;              // |value| up to 32768
    localparam int SENS_CLAMP_W = 4;              // sensitivity after clamping
    localparam int SPEED_W     = 16;              // Q8.8 speed
    localparam int SPEED_FRAC  = 8;
    localparam int DIV_W       = 24;              // dividend / quotient width
    localparam int DEN_W       = 16;              // divisor width
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int ADJ_W       = 18;              // scaled speed, below 2^18
    localparam int LUT_SHIFT   = 13;              // adj * N >> 13 gives the table index
    localparam int SIG_W       = 16;              // Q0.16 sigmoid
    localparam int GAIN_W      = 24;              // Q8.16 gain
    localparam int MUL_CNT_W   = $clog2(MOV_W);

    localparam logic [SENS_W-1:0]  SENS_MIN  = 8'd1;
    localparam logic [SENS_W-1:0]  SENS_MAX  = 8'd10;
    localparam logic [SPEED_W-1:0] SPEED_SAT = 16'hFFFF;
    localparam logic [SIG_W-1:0]   SIG_SAT   = 16'hFFFF;
    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 24'h010000;
    // sensitivity / 2.5 is done as sensitivity * 2 / 5.
    localparam logic [DEN_W-1:0]   SENS_DIV  = 16'd5;
    localparam logic [OUT_W-1:0]   SAT_POS   = 24'h7FFFFF;
    localparam logic [OUT_W-1:0]   SAT_NEG   = 24'h800000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } sssa_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } sssa_div_rsp_t;

endpackage

/* rtl/core/sssa_if.sv */
interface sssa_in_if;
    import sssa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      is_rel;
    logic signed [VALUE_W-1:0] value;
    logic [TIME_W-1:0]         now_ms;
    logic [SENS_W-1:0]         sensitivity;

    modport source (output valid, is_rel, value, now_ms, sensitivity, input ready);
    modport sink   (input valid, is_rel, value, now_ms, sensitivity, output ready);
endinterface

interface sssa_out_if;
    import sssa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] value_out;
    logic                    accelerated;

    modport source (output valid, value_out, accelerated, input ready);
    modport sink   (input valid, value_out, accelerated, output ready);
endinterface

interface sssa_cfg_if;
    import sssa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/sssa_div.sv */
module sssa_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sssa_pkg::sssa_div_req_t req,
    output sssa_pkg::sssa_div_rsp_t rsp
);
    import sssa_pkg::*;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* rtl/core/scroll_speed_sigmoid_accel_top.sv */
// Sigmoid scroll acceleration.
// in_ch carries one scroll event per transfer (is_rel, value, now_ms,
// sensitivity); out_ch returns exactly one result per event (value_out,
// accelerated), in order. cfg writes decay_window_ms (index 0), max_gain
// (index 1) and min_movement (index 2); other indexes are ignored. cfg is
// always ready and is meant to be written only while no event is in flight.
// Events are handled one at a time. A non-relative event, a small movement or
// an event outside the decay window passes from accept through S_EVAL and
// S_DONE into the output register, and the next event can be accepted once it
// is there. An accelerated event takes two passes through the shared bit-serial
// divider (speed, then the sensitivity scaling), 16 shift-add multiply steps
// by the gain and the control states around them.
// The block accepts the next event as soon as the previous one has reached
// the output register, so a stalled receiver holds one finished result while
// the next event is computed; the block stops only when a second result is
// ready and the output register is still full.
// Reset clears the remembered event time (no prior event) and restores the
// registers to 100 ms, gain 10 and threshold 1. No clearing pass is needed.
module scroll_speed_sigmoid_accel_top #(
    parameter int SIGMOID_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    sssa_in_if.sink           in_ch,
    sssa_out_if.source        out_ch,
    sssa_cfg_if.sink          cfg
);
    import sssa_pkg::*;

    localparam int IDX_W  = $clog2(SIGMOID_ENTRIES);
    localparam int N_W    = $clog2(SIGMOID_ENTRIES + 1);
    localparam int PROD_W = ADJ_W + N_W;
    localparam int IDXF_W = PROD_W - LUT_SHIFT;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_IDX   = 4'd5;
    localparam logic [3:0] S_LUT   = 4'd6;
    localparam logic [3:0] S_GAIN  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    typedef logic [SIG_W-1:0] sig_rom_t [SIGMOID_ENTRIES];

    // Sigmoid table, built at elaboration with the same 64-bit fixed-point
    // steps as the software version so every entry matches bit for bit.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-f/65536) in Q32 from a 15-term series.
    function automatic logic [63:0] exp_frac(input logic [31:0] f);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum  = 64'sh1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k <= 14; k++)
        begin
            term = udiv64(term * {32'd0, f}, 64'd65536 * 64'(k));
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return sum[63] ? 64'd0 : sum;
    endfunction

    function automatic logic [63:0] exp_neg(input logic [31:0] a);
        logic [15:0]  n;
        logic [63:0]  r;
        logic [63:0]  e1;
        logic [127:0] prod;
        n  = a[31:16];
        r  = exp_frac({16'd0, a[15:0]});
        e1 = exp_frac(32'd65536);
        for (int i = 0; i < 16; i++)
        begin
            if (16'(i) < n)
            begin
                prod = {64'd0, r} * {64'd0, e1};
                r    = prod[95:32];
            end
        end
        return (n >= 16'd16) ? 64'd0 : r;
    endfunction

    function automatic sig_rom_t build_rom();
        sig_rom_t    rom;
        longint      t;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] s;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            t   = ((longint'(i) << 20) / SIGMOID_ENTRIES) - 64'sd262144;
            a   = (t < 0) ? 64'(-t) : 64'(t);
            e   = exp_neg(a[31:0]);
            d   = 64'h1_0000_0000 + e;
            num = (t >= 0) ? (64'd1 << 48) : (e << 16);
            s   = udiv64(num + (d >> 1), d);
            rom[i] = (s > 64'd65535) ? SIG_SAT : s[SIG_W-1:0];
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_rom();

    // Configuration registers.
    logic [DECAY_W-1:0]    decay_reg;
    logic [GAIN_CFG_W-1:0] max_gain_reg;
    logic [MINMOV_W-1:0]   min_mov_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg    <= DECAY_RESET;
            max_gain_reg <= GAIN_RESET;
            min_mov_reg  <= MINMOV_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DECAY_WINDOW: decay_reg    <= cfg.data[DECAY_W-1:0];
                REG_MAX_GAIN:     max_gain_reg <= cfg.data[GAIN_CFG_W-1:0];
                REG_MIN_MOVEMENT: min_mov_reg  <= cfg.data[MINMOV_W-1:0];
                default:          ;
            endcase
        end
    end

    // Control state.
    logic [3:0]           state_reg, state_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic [MUL_CNT_W-1:0] mcnt_reg, mcnt_next;
    logic                 outv_reg, outv_next;

    // Datapath registers.
    logic                      is_rel_reg, is_rel_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic [SENS_CLAMP_W-1:0]   sens_reg, sens_next;
    logic [MOV_W-1:0]          mov_reg, mov_next;
    logic [SPEED_W-1:0]        speed_reg, speed_next;
    logic [ADJ_W-1:0]          adj_reg, adj_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      ovf_reg, ovf_next;
    logic [SIG_W-1:0]          sig_reg, sig_next;
    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic [GAIN_W-1:0]         hi_reg, hi_next;
    logic [MOV_W-1:0]          lo_reg, lo_next;
    logic [OUT_W-1:0]          res_reg, res_next;
    logic                      res_acc_reg, res_acc_next;
    logic [OUT_W-1:0]          outd_reg, outd_next;
    logic                      outa_reg, outa_next;

    sssa_div_req_t div_req;
    sssa_div_rsp_t div_rsp;

    sssa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic [MOV_W-1:0]      mov;
    logic [TIME_W-1:0]     delta;
    logic                  in_window;
    logic [OUT_W-1:0]      pass_val;
    logic [SENS_CLAMP_W-1:0] sens_clamped;
    logic [19:0]           spd_sens;
    logic [PROD_W-1:0]     idx_prod;
    logic [IDXF_W-1:0]     idx_full;
    logic [GAIN_CFG_W-1:0] gain_m1;
    logic [22:0]           gain_frac;
    logic [GAIN_W:0]       mac_sum;
    logic                  load_out;

    assign mov       = val_reg[VALUE_W-1] ? MOV_W'(-val_reg) : MOV_W'(val_reg);
    assign delta     = (last_reg != '0) ? (now_reg - last_reg) : '0;
    assign in_window = (delta != '0) && (delta < {{(TIME_W-DECAY_W){1'b0}}, decay_reg});
    assign pass_val  = {{(OUT_W-VALUE_W){val_reg[VALUE_W-1]}}, val_reg};

    assign sens_clamped = (in_ch.sensitivity < SENS_MIN) ? SENS_CLAMP_W'(SENS_MIN) :
                          (in_ch.sensitivity > SENS_MAX) ? SENS_CLAMP_W'(SENS_MAX) :
                          in_ch.sensitivity[SENS_CLAMP_W-1:0];

    assign spd_sens = 20'(speed_reg) * 20'(sens_reg);
    assign idx_prod = PROD_W'(adj_reg) * PROD_W'(SIGMOID_ENTRIES);
    assign idx_full = idx_prod[PROD_W-1:LUT_SHIFT];

    // A zero gain setting behaves as a gain of one.
    assign gain_m1   = (max_gain_reg == '0) ? '0 : max_gain_reg - 1'b1;
    assign gain_frac = 23'(gain_m1) * 23'(sig_reg);

    // Shift-add multiply of the magnitude by the gain, LSB first; the low
    // product bits fall out of lo_reg, leaving |value| * gain >> 16 in hi_reg.
    assign mac_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, gain_reg} : '0);

    assign load_out = (state_reg == S_DONE) && (!outv_reg || out_ch.ready);

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = outv_reg;
    assign out_ch.value_out   = outd_reg;
    assign out_ch.accelerated = outa_reg;

    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        mcnt_next    = mcnt_reg;
        is_rel_next  = is_rel_reg;
        val_next     = val_reg;
        now_next     = now_reg;
        sens_next    = sens_reg;
        mov_next     = mov_reg;
        speed_next   = speed_reg;
        adj_next     = adj_reg;
        idx_next     = idx_reg;
        ovf_next     = ovf_reg;
        sig_next     = sig_reg;
        gain_next    = gain_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        res_next     = res_reg;
        res_acc_next = res_acc_reg;
        div_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    is_rel_next = in_ch.is_rel;
                    val_next    = in_ch.value;
                    now_next    = in_ch.now_ms;
                    sens_next   = sens_clamped;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                mov_next     = mov;
                res_next     = pass_val;
                res_acc_next = 1'b0;
                if (!is_rel_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    last_next = now_reg;
                    if ((mov <= MOV_W'(min_mov_reg)) || !in_window)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = {mov, SPEED_FRAC'(0)};
                        div_req.den   = delta[DEN_W-1:0];
                        state_next    = S_DIV1;
                    end
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    speed_next = (div_rsp.quo[DIV_W-1:SPEED_W] != '0) ? SPEED_SAT :
                                 div_rsp.quo[SPEED_W-1:0];
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                div_req.start = 1'b1;
                div_req.num   = {3'b000, spd_sens, 1'b0};
                div_req.den   = SENS_DIV;
                state_next    = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    adj_next   = div_rsp.quo[ADJ_W-1:0];
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                ovf_next   = idx_full >= IDXF_W'(SIGMOID_ENTRIES);
                idx_next   = (idx_full >= IDXF_W'(SIGMOID_ENTRIES)) ? '0 : idx_full[IDX_W-1:0];
                state_next = S_LUT;
            end
            S_LUT:
            begin
                sig_next   = ovf_reg ? SIG_SAT : SIG_ROM[idx_reg];
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                gain_next  = GAIN_ONE + GAIN_W'(gain_frac);
                hi_next    = '0;
                lo_next    = mov_reg;
                mcnt_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                hi_next   = mac_sum[GAIN_W:1];
                lo_next   = {mac_sum[0], lo_reg[MOV_W-1:1]};
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MUL_CNT_W'(MOV_W - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!val_reg[VALUE_W-1])
                    res_next = (hi_reg > SAT_POS) ? SAT_POS : hi_reg;
                else
                    res_next = (hi_reg > SAT_NEG) ? SAT_NEG : OUT_W'(-hi_reg);
                res_acc_next = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a finished result waits here while the next event runs.
    always_comb
    begin
        outv_next = outv_reg;
        outd_next = outd_reg;
        outa_next = outa_reg;
        if (load_out)
        begin
            outv_next = 1'b1;
            outd_next = res_reg;
            outa_next = res_acc_reg;
        end
        else if (out_ch.ready)
        begin
            outv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= '0;
            mcnt_reg  <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            mcnt_reg  <= mcnt_next;
            outv_reg  <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_rel_reg  <= is_rel_next;
        val_reg     <= val_next;
        now_reg     <= now_next;
        sens_reg    <= sens_next;
        mov_reg     <= mov_next;
        speed_reg   <= speed_next;
        adj_reg     <= adj_next;
        idx_reg     <= idx_next;
        ovf_reg     <= ovf_next;
        sig_reg     <= sig_next;
        gain_reg    <= gain_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        res_reg     <= res_next;
        res_acc_reg <= res_acc_next;
        outd_reg    <= outd_next;
        outa_reg    <= outa_next;
    end

endmodule

/* dv/tb_scroll_speed_sigmoid_accel_top.sv */
module tb_scroll_speed_sigmoid_accel_top;
    import sssa_pkg::*;

    localparam int              SIGMOID_ENTRIES = 64;
    localparam int              TOTAL_EVENTS    = 400;
    localparam int              WATCHDOG_LIMIT  = 2000;
    localparam int              DRAIN_CYCLES    = 100;
    localparam longint unsigned ONE_Q32         = 64'h1_0000_0000;
    // Index 3 is not a register; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic               is_rel;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  now_ms;
        logic [SENS_W-1:0]  sensitivity;
    } scroll_event_t;

    typedef struct packed {
        logic [OUT_W-1:0] value_out;
        logic             accelerated;
    } scroll_result_t;

    logic clk;
    logic rst_n = 1'b0;

    sssa_in_if  in_ch ();
    sssa_out_if out_ch ();
    sssa_cfg_if cfg ();

    scroll_speed_sigmoid_accel_top #(
        .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg)
    );

    // Mirror of the block's state and registers.
    logic [TIME_W-1:0]     last_rel_ms;
    logic [DECAY_W-1:0]    decay_cfg;
    logic [GAIN_CFG_W-1:0] gain_cfg;
    logic [MINMOV_W-1:0]   minmov_cfg;
    logic [SIG_W-1:0]      sigmoid_lut [SIGMOID_ENTRIES];

    scroll_result_t    expected_scroll_out [$];
    int unsigned       fail_count;
    int unsigned       results_seen;
    int unsigned       events_sent;
    int unsigned       burst_left;
    int unsigned       quiet_cycles;
    logic [TIME_W-1:0] stream_ms;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // e^(-f/65536) in Q32 from a truncated Taylor series.
    function automatic longint unsigned exp_frac_q32(input longint unsigned f);
        longint signed   acc;
        longint unsigned term;
        int unsigned     k;
        acc  = signed'(ONE_Q32);
        term = ONE_Q32;
        for (k = 1; k <= 14; k++)
        begin
            term = term * f / (64'd65536 * k);
            if (k[0])
                acc -= signed'(term);
            else
                acc += signed'(term);
        end
        if (acc < 0)
            acc = 0;
        return unsigned'(acc);
    endfunction

    initial
    begin : sigmoid_table
        longint signed   t;
        longint unsigned a, e, e1, d, num, s;
        int              i;
        e1 = exp_frac_q32(64'd65536);
        for (i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            t = (longint'(i) <<< 20) / SIGMOID_ENTRIES - 64'sd262144;
            a = (t < 0) ? -t : t;
            if ((a >> 16) >= 16)
                e = 0;
            else
            begin
                e = exp_frac_q32(a & 64'hFFFF);
                // Whole units of the exponent are applied as repeated e^-1 factors.
                repeat (a >> 16) e = (e * e1) >> 32;
            end
            d   = ONE_Q32 + e;
            num = (t >= 0) ? (64'd1 << 48) : (e << 16);
            s   = (num + d / 2) / d;
            if (s > SIG_SAT)
                s = SIG_SAT;
            sigmoid_lut[i] = s[SIG_W-1:0];
        end
    end

    function automatic scroll_result_t predict_scroll(input scroll_event_t ev);
        scroll_result_t    res;
        logic [TIME_W-1:0] elapsed;
        int                delta_in;
        longint unsigned   mag_in, sens, g, speed, adj, idx, sig, gain, mag;
        delta_in        = $signed(ev.value);
        res.value_out   = {{(OUT_W-VALUE_W){ev.value[VALUE_W-1]}}, ev.value};
        res.accelerated = 1'b0;
        if (!ev.is_rel)
            return res;
        elapsed = (last_rel_ms != '0) ? ev.now_ms - last_rel_ms : '0;
        mag_in  = (delta_in < 0) ? -delta_in : delta_in;
        sens    = ev.sensitivity;
        if (sens < SENS_MIN)
            sens = SENS_MIN;
        if (sens > SENS_MAX)
            sens = SENS_MAX;
        if (mag_in <= minmov_cfg)
        begin
            last_rel_ms = ev.now_ms;
            return res;
        end
        if (elapsed != '0 && elapsed < decay_cfg)
        begin
            speed = (mag_in << SPEED_FRAC) / elapsed;
            if (speed > SPEED_SAT)
                speed = SPEED_SAT;
            adj = speed * sens * 2 / SENS_DIV;
            idx = (adj * SIGMOID_ENTRIES) >> LUT_SHIFT;
            sig = (idx < SIGMOID_ENTRIES) ? sigmoid_lut[idx] : SIG_SAT;
            g    = (gain_cfg == '0) ? 1 : gain_cfg;
            gain = GAIN_ONE + (g - 1) * sig;
            mag  = (mag_in * gain) >> 16;
            if (delta_in >= 0)
            begin
                if (mag > SAT_POS)
                    mag = SAT_POS;
                res.value_out = OUT_W'(mag);
            end
            else
            begin
                if (mag > SAT_NEG)
                    mag = SAT_NEG;
                res.value_out = OUT_W'(0 - mag);
            end
            res.accelerated = 1'b1;
        end
        last_rel_ms = ev.now_ms;
        return res;
    endfunction

    function automatic scroll_event_t mk_event(input logic rel, input int delta,
                                               input logic [TIME_W-1:0] at_ms,
                                               input int sens);
        scroll_event_t ev;
        ev.is_rel      = rel;
        ev.value       = VALUE_W'(delta);
        ev.now_ms      = at_ms;
        ev.sensitivity = SENS_W'(sens);
        return ev;
    endfunction

    // Mostly well-formed streams of relative events spaced inside the window,
    // with non-relative events, time jumps and restarts at time zero mixed in.
    function automatic scroll_event_t rand_scroll_event();
        int unsigned pick;
        int unsigned mag;
        int unsigned step;
        int unsigned step_cap;
        int          sens;
        logic        rel;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       mag = $urandom_range(0, 3);
            1:       mag = ($urandom_range(0, 1) == 0) ? 32768 : minmov_cfg + 1;
            2, 3:    mag = $urandom_range(0, 32768);
            default: mag = $urandom_range(4, 600);
        endcase
        sens = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        rel  = 1'b1;
        if (pick < 8)
        begin
            rel       = 1'b0;
            stream_ms = stream_ms;
        end
        else if (pick < 12)
            stream_ms = $urandom;
        else if (pick < 14)
            stream_ms = '0;
        else
        begin
            if (decay_cfg >= 2 && $urandom_range(0, 3) != 0)
            begin
                step_cap = (decay_cfg - 1 < 250) ? decay_cfg - 1 : 250;
                step     = $urandom_range(1, step_cap);
            end
            else if ($urandom_range(0, 2) == 0)
                step = 0;
            else
                step = decay_cfg + $urandom_range(0, 40);
            stream_ms = stream_ms + step;
        end
        return mk_event(rel, ($urandom_range(0, 1) != 0) ? -int'(mag) : int'(mag),
                        rel ? stream_ms : TIME_W'($urandom), sens);
    endfunction

    task automatic send_event(input scroll_event_t ev);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_ch.valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        in_ch.valid       = 1'b1;
        in_ch.is_rel      = ev.is_rel;
        in_ch.value       = ev.value;
        in_ch.now_ms      = ev.now_ms;
        in_ch.sensitivity = ev.sensitivity;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_scroll_out.push_back(predict_scroll(ev));
        burst_left--;
        events_sent++;
    endtask

    // Stops the event stream and waits until every result has come back.
    task automatic settle_block();
        @(negedge clk);
        in_ch.valid = 1'b0;
        burst_left  = 0;
        while (expected_scroll_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = data;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            REG_DECAY_WINDOW: decay_cfg  = data[DECAY_W-1:0];
            REG_MAX_GAIN:     gain_cfg   = data[GAIN_CFG_W-1:0];
            REG_MIN_MOVEMENT: minmov_cfg = data[MINMOV_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic set_registers(input logic [DECAY_W-1:0] decay,
                                 input logic [GAIN_CFG_W-1:0] gain,
                                 input logic [MINMOV_W-1:0] minmov);
        settle_block();
        write_reg(REG_DECAY_WINDOW, CFG_DATA_W'(decay));
        write_reg(REG_MAX_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_MIN_MOVEMENT, CFG_DATA_W'(minmov));
    endtask

    task automatic run_random_events(input int unsigned count);
        int unsigned j;
        // Some streams start just below the 32-bit wrap of the timestamp.
        stream_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                : TIME_W'($urandom);
        for (j = 0; j < count; j++)
            send_event(rand_scroll_event());
    endtask

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    task automatic test_directed_events();
        send_event(mk_event(1'b0, -32768, 32'hFFFF_FFFF, 255));
        send_event(mk_event(1'b1, 300, 32'd0, 5));
        send_event(mk_event(1'b1, 300, 32'd1000, 5));
        send_event(mk_event(1'b1, 300, 32'd1010, 5));
        send_event(mk_event(1'b1, 32767, 32'd1011, 255));
        send_event(mk_event(1'b1, -32768, 32'd1012, 0));
        send_event(mk_event(1'b1, 1, 32'd1013, 5));
        send_event(mk_event(1'b1, -1, 32'd1014, 5));
        send_event(mk_event(1'b1, 0, 32'd1015, 5));
        send_event(mk_event(1'b1, 2, 32'd1016, 10));
        // A non-relative event in between must not move the remembered time.
        send_event(mk_event(1'b0, 7, 32'd1050, 4));
        send_event(mk_event(1'b1, -40, 32'd1116, 3));
        send_event(mk_event(1'b1, 40, 32'd1215, 3));
        send_event(mk_event(1'b1, 40, 32'd1215, 3));
        send_event(mk_event(1'b1, 100, 32'hFFFF_FFF0, 6));
        send_event(mk_event(1'b1, 100, 32'd5, 6));
        // Landing on time zero brings back the no-prior-event condition.
        send_event(mk_event(1'b1, 100, 32'd0, 6));
        send_event(mk_event(1'b1, 100, 32'd5, 6));
        send_event(mk_event(1'b1, 32767, 32'd6, 8'hAA));
        send_event(mk_event(1'b1, 16'h5555, 32'd7, 8'h55));
        send_event(mk_event(1'b1, -2, 32'd8, 1));
    endtask

    task automatic test_register_extremes();
        set_registers(16'd0, 7'd10, 15'd1);
        run_random_events(20);
        set_registers(16'hFFFF, 7'd0, 15'd0);
        run_random_events(25);
        set_registers(16'd250, 7'h7F, 15'h7FFF);
        run_random_events(20);
        settle_block();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        run_random_events(10);
        set_registers(16'd1, 7'd100, 15'd0);
        run_random_events(10);
    endtask

    task automatic test_random_traffic();
        logic [DECAY_W-1:0]    decay;
        logic [GAIN_CFG_W-1:0] gain;
        logic [MINMOV_W-1:0]   minmov;
        while (events_sent < TOTAL_EVENTS)
        begin
            decay  = ($urandom_range(0, 5) == 0) ? DECAY_W'($urandom_range(0, 65535))
                                                 : DECAY_W'($urandom_range(2, 300));
            gain   = ($urandom_range(0, 4) == 0) ? GAIN_CFG_W'($urandom_range(0, 127))
                                                 : GAIN_CFG_W'($urandom_range(1, 100));
            minmov = ($urandom_range(0, 5) == 0) ? MINMOV_W'($urandom_range(0, 32767))
                                                 : MINMOV_W'($urandom_range(0, 8));
            set_registers(decay, gain, minmov);
            run_random_events($urandom_range(25, 50));
        end
    endtask

    // Receiver back-pressure cycles through free flow, light random stalls,
    // long periodic stalls and a rotating bit pattern.
    initial
    begin : sink_ready
        int unsigned       cyc;
        logic [15:0]       pat;
        out_ch.ready = 1'b0;
        cyc = 0;
        pat = 16'h0101;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (cyc % 300 == 0)
                pat = 16'($urandom) | 16'h0101;
            case ((cyc / 300) % 4)
                0: out_ch.ready = 1'b1;
                1: out_ch.ready = ($urandom_range(0, 3) != 0);
                2: out_ch.ready = ((cyc % 23) < 3);
                default:
                begin
                    pat          = {pat[14:0], pat[15]};
                    out_ch.ready = pat[0];
                end
            endcase
            cyc++;
        end
    end

    always @(posedge clk)
    begin : result_check
        scroll_result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_scroll_out.size() == 0)
                    note_failure($sformatf("result %0d arrived with none expected: %0d/%0b",
                                           results_seen, $signed(out_ch.value_out),
                                           out_ch.accelerated));
                else
                begin
                    want = expected_scroll_out.pop_front();
                    if (out_ch.value_out !== want.value_out ||
                        out_ch.accelerated !== want.accelerated)
                        note_failure($sformatf({"result %0d mismatch: value_out exp %0d got %0d,",
                                                " accelerated exp %0b got %0b"},
                                               results_seen, $signed(want.value_out),
                                               $signed(out_ch.value_out), want.accelerated,
                                               out_ch.accelerated));
                end
                results_seen++;
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** scroll_speed_sigmoid_accel_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.is_rel      = 1'b0;
        in_ch.value       = '0;
        in_ch.now_ms      = '0;
        in_ch.sensitivity = '0;
        cfg.valid         = 1'b0;
        cfg.index         = REG_DECAY_WINDOW;
        cfg.data          = '0;
        last_rel_ms       = '0;
        decay_cfg         = DECAY_RESET;
        gain_cfg          = GAIN_RESET;
        minmov_cfg        = MINMOV_RESET;
        fail_count        = 0;
        results_seen      = 0;
        events_sent       = 0;
        burst_left        = 0;
        quiet_cycles      = 0;
        stream_ms         = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_events();
        test_register_extremes();
        test_random_traffic();

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_scroll_out.size() == 0)
            $display("** scroll_speed_sigmoid_accel_top: PASSED **");
        else
            $display("** scroll_speed_sigmoid_accel_top: FAILED **");
        $finish;
    end

endmodule
